// File: rtl/pgbi_pkg.sv
// pgbi_pkg: shared types, widths and constants of the grid bilinear interpolator
// no dependencies
`timescale 1ns / 1ps

package pgbi_pkg;

    localparam int GRID_COLS_DEF = 24;
    localparam int GRID_ROWS_DEF = 24;

    localparam int COORD_W  = 18;
    localparam int ANG_W    = 18;
    localparam int ID_W     = 10;
    localparam int SIZE_W   = 14;
    localparam int IDX_IN_W = 5;

    localparam int NUM_W   = 22;
    localparam int PITCH_W = 16;
    localparam int DIFF_W  = 19;
    localparam int WGT_W   = 38;
    localparam int LO_W    = WGT_W / 2;
    localparam int MUL_W   = 20;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 59;
    localparam int DIV_NW  = ACC_W - 1;
    localparam int DIV_DW  = WGT_W;

    localparam int MAX_RESET  = -64000;
    localparam int ANG_MAX    = 131071;
    localparam int ANG_MIN    = -131072;
    localparam int SIZE_RESET = 3328;
    localparam int GAP_RESET  = 64;

    typedef enum logic [0:0] {
        REG_TILE_SIZE = 1'b0,
        REG_TILE_GAP  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEL_C = 2'd0,
        SEL_A = 2'd1,
        SEL_B = 2'd2,
        SEL_D = 2'd3
    } nbr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVX,
        ST_WAITX,
        ST_DIVY,
        ST_WAITY,
        ST_READ,
        ST_CAPT,
        ST_WMUL,
        ST_WSTO,
        ST_AMUL,
        ST_AACC,
        ST_ADIV,
        ST_AWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                       valid;
        logic [ID_W-1:0]            id;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [ANG_W-1:0]    th;
        logic signed [ANG_W-1:0]    ph;
    } tile_rec_t;

    typedef struct packed {
        logic clearing;
    } tbl_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [ACC_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > ANG_MAX)
        begin
            r = ANG_W'(ANG_MAX);
        end
        else if (v < ANG_MIN)
        begin
            r = ANG_W'(ANG_MIN);
        end
        else
        begin
            r = ANG_W'(v);
        end
        return r;
    endfunction

endpackage

// File: rtl/pgbi_table.sv
// pgbi_table: tile entry memory, one write and one registered read port
// clears every entry after reset; uses pgbi_pkg
`timescale 1ns / 1ps

module pgbi_table
    import pgbi_pkg::*;
#(
    parameter int DEPTH = GRID_COLS_DEF * GRID_ROWS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  tile_rec_t         wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output tile_rec_t         rd_data,
    output tbl_stat_t         stat
);

    tile_rec_t         mem [0:DEPTH-1];
    tile_rec_t         rd_data_reg;
    logic              clr_reg;
    logic              clr_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data       = rd_data_reg;
    assign stat.clearing = clr_reg;

endmodule

// File: rtl/pgbi_divider.sv
// pgbi_divider: signed restoring divider, one quotient bit per cycle, truncating
// uses pgbi_pkg
`timescale 1ns / 1ps

module pgbi_divider
    import pgbi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic signed [DIV_DW:0]  divisor,
    output logic signed [ACC_W-1:0] quotient,
    output div_stat_t               stat
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_NW-1:0] num_next;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] den_next;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] rem_next;
    logic              neg_reg;
    logic              neg_next;

    logic signed [ACC_W-1:0]  abs_n;
    logic signed [DIV_DW:0]   abs_d;
    logic [DIV_DW:0]          trial;
    logic                     ge;

    always_comb
    begin
        abs_n     = dividend[ACC_W-1] ? -dividend : dividend;
        abs_d     = divisor[DIV_DW] ? -divisor : divisor;
        trial     = {rem_reg, num_reg[DIV_NW-1]};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = abs_n[DIV_NW-1:0];
            den_next  = abs_d[DIV_DW-1:0];
            rem_next  = '0;
            neg_next  = dividend[ACC_W-1] ^ divisor[DIV_DW];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
            num_next = {num_reg[DIV_NW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign quotient  = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/pmt_grid_bilinear_interpolator.sv
// pmt_grid_bilinear_interpolator: tile grid table with bilinear angle interpolation
// uses pgbi_pkg, pgbi_table, pgbi_divider
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   kind, grid_col, grid_row, tile_id, pos_*, load_*
// out       output     out_valid / out_stall found, hit_tile_id, interp_theta, interp_phi
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a query runs the shared divider four times (two pitch divisions, two area
// divisions) plus four table reads
// after reset the table is cleared entry by entry with in_stall high
// a finished result waits in the output register while the next item is accepted
`timescale 1ns / 1ps

module pmt_grid_bilinear_interpolator
    import pgbi_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [IDX_IN_W-1:0]       grid_col,
    input  logic [IDX_IN_W-1:0]       grid_row,
    input  logic [ID_W-1:0]           tile_id,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [ANG_W-1:0]   load_theta,
    input  logic signed [ANG_W-1:0]   load_phi,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [ID_W-1:0]           hit_tile_id,
    output logic signed [ANG_W-1:0]   interp_theta,
    output logic signed [ANG_W-1:0]   interp_phi,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [SIZE_W-1:0]         cfg_data
);

    localparam int DEPTH  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int SC_W   = COL_W + 2;
    localparam int SR_W   = ROW_W + 2;

    state_t                    state_reg, state_next;
    logic [SIZE_W-1:0]         size_reg, size_next;
    logic [SIZE_W-1:0]         gap_reg, gap_next;
    logic signed [COORD_W-1:0] max_x_reg, max_x_next;
    logic signed [COORD_W-1:0] max_y_reg, max_y_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic signed [NUM_W-1:0]   nx_reg, nx_next;
    logic signed [NUM_W-1:0]   ny_reg, ny_next;
    logic [PITCH_W-1:0]        pitch_reg, pitch_next;
    logic [COL_W-1:0]          ix_reg, ix_next;
    logic [ROW_W-1:0]          iy_reg, iy_next;
    logic                      ixok_reg, ixok_next;
    nbr_sel_t                  sel_reg, sel_next;
    logic                      inr_reg, inr_next;
    logic                      sxn_reg, sxn_next;
    logic                      syn_reg, syn_next;
    logic [ID_W-1:0]           c_id_reg, c_id_next;
    logic signed [COORD_W-1:0] c_x_reg, c_x_next;
    logic signed [COORD_W-1:0] c_y_reg, c_y_next;
    logic signed [ANG_W-1:0]   c_th_reg, c_th_next;
    logic signed [ANG_W-1:0]   c_ph_reg, c_ph_next;
    logic signed [COORD_W-1:0] xa_reg, xa_next;
    logic signed [COORD_W-1:0] yb_reg, yb_next;
    logic signed [ANG_W-1:0]   ta_reg, ta_next;
    logic signed [ANG_W-1:0]   pa_reg, pa_next;
    logic signed [ANG_W-1:0]   tb_reg, tb_next;
    logic signed [ANG_W-1:0]   pb_reg, pb_next;
    logic signed [ANG_W-1:0]   td_reg, td_next;
    logic signed [ANG_W-1:0]   pd_reg, pd_next;
    logic [2:0]                wk_reg, wk_next;
    logic signed [WGT_W-1:0]   w_reg [0:3];
    logic signed [WGT_W-1:0]   w_next [0:3];
    logic signed [WGT_W-1:0]   d_reg, d_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [2:0]                am_reg, am_next;
    logic                      phi_reg, phi_next;
    logic                      res_found_reg, res_found_next;
    logic [ID_W-1:0]           res_id_reg, res_id_next;
    logic signed [ANG_W-1:0]   res_th_reg, res_th_next;
    logic signed [ANG_W-1:0]   res_ph_reg, res_ph_next;
    logic                      o_found_reg, o_found_next;
    logic [ID_W-1:0]           o_id_reg, o_id_next;
    logic signed [ANG_W-1:0]   o_th_reg, o_th_next;
    logic signed [ANG_W-1:0]   o_ph_reg, o_ph_next;

    logic                      tbl_wr_en;
    logic [ADDR_W-1:0]         tbl_wr_addr;
    tile_rec_t                 tbl_wr_data;
    logic                      tbl_rd_en;
    logic [ADDR_W-1:0]         tbl_rd_addr;
    tile_rec_t                 tbl_rd_data;
    tbl_stat_t                 tbl_stat;

    logic                      div_start;
    logic signed [ACC_W-1:0]   div_dividend;
    logic signed [DIV_DW:0]    div_divisor;
    logic signed [ACC_W-1:0]   div_quot;
    div_stat_t                 div_stat;

    logic                      in_xfer;
    logic signed [COORD_W:0]   neg_mx, neg_my, cx1, cy1, cx, cy;
    logic [SIZE_W:0]           pitch_half;
    logic signed [SC_W-1:0]    col_s;
    logic signed [SR_W-1:0]    row_s;
    logic                      col_ok, row_ok, pres, q_ok_x, q_ok_y;
    logic signed [DIFF_W-1:0]  dxa, dxc, dyb, dyc, ddx, ddy;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    nbr_sel_t                  term;
    logic signed [ANG_W-1:0]   ang;
    logic signed [WGT_W-1:0]   wsel;
    logic signed [ACC_W-1:0]   term_val;

    pgbi_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .stat    (tbl_stat)
    );

    pgbi_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign in_stall  = tbl_stat.clearing || (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        neg_mx     = -(COORD_W + 1)'(max_x_reg);
        neg_my     = -(COORD_W + 1)'(max_y_reg);
        cx1        = (pos_x > max_x_reg) ? (COORD_W + 1)'(max_x_reg) : (COORD_W + 1)'(pos_x);
        cy1        = (pos_y > max_y_reg) ? (COORD_W + 1)'(max_y_reg) : (COORD_W + 1)'(pos_y);
        cx         = (cx1 < neg_mx) ? neg_mx : cx1;
        cy         = (cy1 < neg_my) ? neg_my : cy1;
        pitch_half = {1'b0, size_reg} + {1'b0, gap_reg};

        col_s  = $signed(SC_W'(ix_reg));
        row_s  = $signed(SR_W'(iy_reg));
        if (sel_reg == SEL_A || sel_reg == SEL_D)
        begin
            col_s = sxn_reg ? col_s - SC_W'(1) : col_s + SC_W'(1);
        end
        if (sel_reg == SEL_B || sel_reg == SEL_D)
        begin
            row_s = syn_reg ? row_s - SR_W'(1) : row_s + SR_W'(1);
        end
        col_ok = (col_s >= 0) && (col_s < GRID_COLS);
        row_ok = (row_s >= 0) && (row_s < GRID_ROWS);
        pres   = inr_reg && tbl_rd_data.valid;
        q_ok_x = !div_quot[ACC_W-1] && (div_quot < GRID_COLS);
        q_ok_y = !div_quot[ACC_W-1] && (div_quot < GRID_ROWS);

        dxa = DIFF_W'(xa_reg) - DIFF_W'(px_reg);
        dxc = DIFF_W'(c_x_reg) - DIFF_W'(px_reg);
        dyb = DIFF_W'(yb_reg) - DIFF_W'(py_reg);
        dyc = DIFF_W'(c_y_reg) - DIFF_W'(py_reg);
        ddx = DIFF_W'(xa_reg) - DIFF_W'(c_x_reg);
        ddy = DIFF_W'(yb_reg) - DIFF_W'(c_y_reg);

        term = nbr_sel_t'(am_reg[2:1]);
        unique case (term)
            SEL_C: ang = phi_reg ? c_ph_reg : c_th_reg;
            SEL_A: ang = phi_reg ? pa_reg : ta_reg;
            SEL_B: ang = phi_reg ? pb_reg : tb_reg;
            SEL_D: ang = phi_reg ? pd_reg : td_reg;
            default: ang = c_th_reg;
        endcase
        wsel = w_reg[am_reg[2:1]];

        if (state_reg == ST_WMUL)
        begin
            unique case (wk_reg)
                3'd0:
                begin
                    mul_a = MUL_W'(dxa);
                    mul_b = MUL_W'(dyb);
                end
                3'd1:
                begin
                    mul_a = MUL_W'(dxc);
                    mul_b = MUL_W'(dyb);
                end
                3'd2:
                begin
                    mul_a = MUL_W'(dxa);
                    mul_b = MUL_W'(dyc);
                end
                3'd3:
                begin
                    mul_a = MUL_W'(dxc);
                    mul_b = MUL_W'(dyc);
                end
                default:
                begin
                    mul_a = MUL_W'(ddx);
                    mul_b = MUL_W'(ddy);
                end
            endcase
        end
        else
        begin
            mul_a = MUL_W'(ang);
            mul_b = am_reg[0] ? $signed(MUL_W'(wsel[LO_W-1:0]))
                              : MUL_W'($signed(wsel[WGT_W-1:LO_W]));
        end

        term_val = am_reg[0] ? ACC_W'(prod_reg) : (ACC_W'(prod_reg) <<< LO_W);
    end

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        gap_next       = gap_reg;
        max_x_next     = max_x_reg;
        max_y_next     = max_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        px_next        = px_reg;
        py_next        = py_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        pitch_next     = pitch_reg;
        ix_next        = ix_reg;
        iy_next        = iy_reg;
        ixok_next      = ixok_reg;
        sel_next       = sel_reg;
        inr_next       = inr_reg;
        sxn_next       = sxn_reg;
        syn_next       = syn_reg;
        c_id_next      = c_id_reg;
        c_x_next       = c_x_reg;
        c_y_next       = c_y_reg;
        c_th_next      = c_th_reg;
        c_ph_next      = c_ph_reg;
        xa_next        = xa_reg;
        yb_next        = yb_reg;
        ta_next        = ta_reg;
        pa_next        = pa_reg;
        tb_next        = tb_reg;
        pb_next        = pb_reg;
        td_next        = td_reg;
        pd_next        = pd_reg;
        wk_next        = wk_reg;
        w_next         = w_reg;
        d_next         = d_reg;
        prod_next      = mul_a * mul_b;
        acc_next       = acc_reg;
        am_next        = am_reg;
        phi_next       = phi_reg;
        res_found_next = res_found_reg;
        res_id_next    = res_id_reg;
        res_th_next    = res_th_reg;
        res_ph_next    = res_ph_reg;
        o_found_next   = o_found_reg;
        o_id_next      = o_id_reg;
        o_th_next      = o_th_reg;
        o_ph_next      = o_ph_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = ADDR_W'(grid_row) * ADDR_W'(GRID_COLS) + ADDR_W'(grid_col);
        tbl_wr_data    = '{valid: 1'b1, id: tile_id, x: pos_x, y: pos_y,
                           th: load_theta, ph: load_phi};
        tbl_rd_en      = 1'b0;
        tbl_rd_addr    = ADDR_W'(row_s[ROW_W-1:0]) * ADDR_W'(GRID_COLS)
                       + ADDR_W'(col_s[COL_W-1:0]);
        div_start      = 1'b0;
        div_dividend   = acc_reg;
        div_divisor    = (DIV_DW + 1)'(d_reg);

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TILE_SIZE)
            begin
                size_next = cfg_data;
            end
            else
            begin
                gap_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && !kind)
                begin
                    if ((32'(grid_col) < GRID_COLS) && (32'(grid_row) < GRID_ROWS))
                    begin
                        tbl_wr_en = 1'b1;
                        if (pos_x > max_x_reg)
                        begin
                            max_x_next = pos_x;
                        end
                        if (pos_y > max_y_reg)
                        begin
                            max_y_next = pos_y;
                        end
                    end
                end
                else if (in_xfer)
                begin
                    px_next        = pos_x;
                    py_next        = pos_y;
                    nx_next        = (NUM_W'(max_x_reg) <<< 1) + $signed(NUM_W'(size_reg))
                                   - (NUM_W'(cx) <<< 1);
                    ny_next        = (NUM_W'(max_y_reg) <<< 1) + $signed(NUM_W'(size_reg))
                                   - (NUM_W'(cy) <<< 1);
                    pitch_next     = {pitch_half, 1'b0};
                    res_found_next = 1'b0;
                    res_id_next    = '0;
                    res_th_next    = '0;
                    res_ph_next    = '0;
                    state_next     = (pitch_half == '0) ? ST_DONE : ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                div_start    = 1'b1;
                div_dividend = ACC_W'(nx_reg);
                div_divisor  = $signed((DIV_DW + 1)'(pitch_reg));
                state_next   = ST_WAITX;
            end
            ST_WAITX:
            begin
                if (div_stat.done)
                begin
                    ixok_next  = q_ok_x;
                    ix_next    = div_quot[COL_W-1:0];
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                div_start    = 1'b1;
                div_dividend = ACC_W'(ny_reg);
                div_divisor  = $signed((DIV_DW + 1)'(pitch_reg));
                state_next   = ST_WAITY;
            end
            ST_WAITY:
            begin
                if (div_stat.done)
                begin
                    iy_next = div_quot[ROW_W-1:0];
                    if (ixok_reg && q_ok_y)
                    begin
                        sel_next   = SEL_C;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                tbl_rd_en  = 1'b1;
                inr_next   = col_ok && row_ok;
                state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                sel_next   = nbr_sel_t'(sel_reg + 2'd1);
                state_next = ST_READ;
                unique case (sel_reg)
                    SEL_C:
                    begin
                        if (!pres)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            c_id_next      = tbl_rd_data.id;
                            c_x_next       = tbl_rd_data.x;
                            c_y_next       = tbl_rd_data.y;
                            c_th_next      = tbl_rd_data.th;
                            c_ph_next      = tbl_rd_data.ph;
                            sxn_next       = px_reg > tbl_rd_data.x;
                            syn_next       = py_reg > tbl_rd_data.y;
                            res_found_next = 1'b1;
                            res_id_next    = tbl_rd_data.id;
                        end
                    end
                    SEL_A:
                    begin
                        xa_next = pres ? tbl_rd_data.x : c_x_reg;
                        ta_next = pres ? tbl_rd_data.th : c_th_reg;
                        pa_next = pres ? tbl_rd_data.ph : c_ph_reg;
                    end
                    SEL_B:
                    begin
                        yb_next = pres ? tbl_rd_data.y : c_y_reg;
                        tb_next = pres ? tbl_rd_data.th : c_th_reg;
                        pb_next = pres ? tbl_rd_data.ph : c_ph_reg;
                    end
                    SEL_D:
                    begin
                        td_next    = pres ? tbl_rd_data.th : c_th_reg;
                        pd_next    = pres ? tbl_rd_data.ph : c_ph_reg;
                        wk_next    = '0;
                        state_next = ST_WMUL;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WMUL:
            begin
                state_next = ST_WSTO;
            end
            ST_WSTO:
            begin
                if (wk_reg == 3'd4)
                begin
                    d_next = WGT_W'(prod_reg);
                    if (prod_reg == '0)
                    begin
                        res_th_next = c_th_reg;
                        res_ph_next = c_ph_reg;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        am_next    = '0;
                        phi_next   = 1'b0;
                        state_next = ST_AMUL;
                    end
                end
                else
                begin
                    w_next[wk_reg[1:0]] = WGT_W'(prod_reg);
                    wk_next    = wk_reg + 3'd1;
                    state_next = ST_WMUL;
                end
            end
            ST_AMUL:
            begin
                state_next = ST_AACC;
            end
            ST_AACC:
            begin
                acc_next = (term == SEL_A || term == SEL_B) ? acc_reg - term_val
                                                            : acc_reg + term_val;
                am_next    = am_reg + 3'd1;
                state_next = (am_reg == 3'd7) ? ST_ADIV : ST_AMUL;
            end
            ST_ADIV:
            begin
                div_start  = 1'b1;
                state_next = ST_AWAIT;
            end
            ST_AWAIT:
            begin
                if (div_stat.done)
                begin
                    if (!phi_reg)
                    begin
                        res_th_next = sat_angle(div_quot);
                        phi_next    = 1'b1;
                        acc_next    = '0;
                        am_next     = '0;
                        state_next  = ST_AMUL;
                    end
                    else
                    begin
                        res_ph_next = sat_angle(div_quot);
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    o_found_next   = res_found_reg;
                    o_id_next      = res_id_reg;
                    o_th_next      = res_th_reg;
                    o_ph_next      = res_ph_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_W'(SIZE_RESET);
            gap_reg       <= SIZE_W'(GAP_RESET);
            max_x_reg     <= COORD_W'(MAX_RESET);
            max_y_reg     <= COORD_W'(MAX_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            gap_reg       <= gap_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        nx_reg        <= nx_next;
        ny_reg        <= ny_next;
        pitch_reg     <= pitch_next;
        ix_reg        <= ix_next;
        iy_reg        <= iy_next;
        ixok_reg      <= ixok_next;
        sel_reg       <= sel_next;
        inr_reg       <= inr_next;
        sxn_reg       <= sxn_next;
        syn_reg       <= syn_next;
        c_id_reg      <= c_id_next;
        c_x_reg       <= c_x_next;
        c_y_reg       <= c_y_next;
        c_th_reg      <= c_th_next;
        c_ph_reg      <= c_ph_next;
        xa_reg        <= xa_next;
        yb_reg        <= yb_next;
        ta_reg        <= ta_next;
        pa_reg        <= pa_next;
        tb_reg        <= tb_next;
        pb_reg        <= pb_next;
        td_reg        <= td_next;
        pd_reg        <= pd_next;
        wk_reg        <= wk_next;
        w_reg         <= w_next;
        d_reg         <= d_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        am_reg        <= am_next;
        phi_reg       <= phi_next;
        res_found_reg <= res_found_next;
        res_id_reg    <= res_id_next;
        res_th_reg    <= res_th_next;
        res_ph_reg    <= res_ph_next;
        o_found_reg   <= o_found_next;
        o_id_reg      <= o_id_next;
        o_th_reg      <= o_th_next;
        o_ph_reg      <= o_ph_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = o_found_reg;
    assign hit_tile_id  = o_id_reg;
    assign interp_theta = o_th_reg;
    assign interp_phi   = o_ph_reg;

endmodule

// File: rtl/pgbi_checker.sv
// pgbi_checker: port level assertions for the grid bilinear interpolator
// bound to pmt_grid_bilinear_interpolator; uses pgbi_pkg
`timescale 1ns / 1ps

module pgbi_checker
    import pgbi_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      kind,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      found,
    input logic [ID_W-1:0]           hit_tile_id,
    input logic signed [ANG_W-1:0]   interp_theta,
    input logic signed [ANG_W-1:0]   interp_phi
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(hit_tile_id)
            && $stable(interp_theta) && $stable(interp_phi))
        else $error("stalled result changed");

    // a miss carries zero payload
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> hit_tile_id == '0 && interp_theta == '0 && interp_phi == '0)
        else $error("miss with nonzero payload");

    // a query transfer blocks the input while it is worked on
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind |=> in_stall)
        else $error("input taken during a query");

    // no result appears right after an input transfer
    a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind pmt_grid_bilinear_interpolator pgbi_checker u_pgbi_checker (.*);

// File: dv/tb_pmt_grid_bilinear_interpolator.sv
// testbench for pmt_grid_bilinear_interpolator: loads tile grids, runs interpolation queries
// and checks every result against a built-in table predictor; depends on pgbi_pkg and the rtl
`timescale 1ns / 1ps

module tb_pmt_grid_bilinear_interpolator;
    import pgbi_pkg::*;

    localparam int NCOLS = 24;
    localparam int NROWS = 24;
    localparam longint EDGE_POS = 131071;

    typedef struct {
        bit              kind;
        bit [4:0]        col;
        bit [4:0]        row;
        bit [9:0]        id;
        longint          x;
        longint          y;
        longint          th;
        longint          ph;
    } grid_item_t;

    typedef struct {
        bit              found;
        bit [9:0]        id;
        bit [17:0]       th;
        bit [17:0]       ph;
    } interp_result_t;

    class interp_scoreboard;
        bit              valid[NROWS][NCOLS];
        longint          cx_t[NROWS][NCOLS];
        longint          cy_t[NROWS][NCOLS];
        longint          th_t[NROWS][NCOLS];
        longint          ph_t[NROWS][NCOLS];
        bit [9:0]        id_t[NROWS][NCOLS];
        longint          max_x;
        longint          max_y;
        longint          tile_size;
        longint          tile_gap;
        interp_result_t  pending[$];
        int              errors;

        function new();
            foreach (valid[r, c])
                valid[r][c] = 1'b0;
            max_x = MAX_RESET;
            max_y = MAX_RESET;
            tile_size = SIZE_RESET;
            tile_gap = GAP_RESET;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, int unsigned v);
            if (idx == REG_TILE_SIZE)
                tile_size = v;
            else
                tile_gap = v;
        endfunction

        function bit present(longint c, longint r);
            if (c < 0 || r < 0 || c >= NCOLS || r >= NROWS)
                return 1'b0;
            return valid[r][c];
        endfunction

        function longint limit_angle(longint v);
            if (v > ANG_MAX)
                return ANG_MAX;
            if (v < ANG_MIN)
                return ANG_MIN;
            return v;
        endfunction

        function longint mix(longint c, longint a, longint b, longint dg, longint xc,
                             longint xa, longint yc, longint yb, longint x, longint y,
                             longint d);
            longint n;
            n = c * ((xa - x) * (yb - y)) - a * ((xc - x) * (yb - y))
                - b * ((xa - x) * (yc - y)) + dg * ((xc - x) * (yc - y));
            return limit_angle(n / d);
        endfunction

        function void note_input(grid_item_t it);
            interp_result_t res;
            longint p2, hx, hy, ix, iy, sx, sy, xc, yc, xa, yb, d;
            longint ta, pa, tb, pb, td, pd, th, ph;
            if (!it.kind)
            begin
                if (it.col < NCOLS && it.row < NROWS)
                begin
                    valid[it.row][it.col] = 1'b1;
                    id_t[it.row][it.col] = it.id;
                    cx_t[it.row][it.col] = it.x;
                    cy_t[it.row][it.col] = it.y;
                    th_t[it.row][it.col] = it.th;
                    ph_t[it.row][it.col] = it.ph;
                    if (it.x > max_x)
                        max_x = it.x;
                    if (it.y > max_y)
                        max_y = it.y;
                end
                return;
            end
            res = '{default: 0};
            p2 = 2 * (tile_size + tile_gap);
            if (p2 != 0)
            begin
                hx = it.x;
                hy = it.y;
                if (hx > max_x) hx = max_x;
                if (hx < -max_x) hx = -max_x;
                if (hy > max_y) hy = max_y;
                if (hy < -max_y) hy = -max_y;
                ix = (2 * max_x + tile_size - 2 * hx) / p2;
                iy = (2 * max_y + tile_size - 2 * hy) / p2;
                if (present(ix, iy))
                begin
                    xc = cx_t[iy][ix];
                    yc = cy_t[iy][ix];
                    sx = (it.x > xc) ? -1 : 1;
                    sy = (it.y > yc) ? -1 : 1;
                    xa = xc; ta = th_t[iy][ix]; pa = ph_t[iy][ix];
                    yb = yc; tb = ta; pb = pa; td = ta; pd = pa;
                    if (present(ix + sx, iy))
                    begin
                        xa = cx_t[iy][ix + sx];
                        ta = th_t[iy][ix + sx];
                        pa = ph_t[iy][ix + sx];
                    end
                    if (present(ix, iy + sy))
                    begin
                        yb = cy_t[iy + sy][ix];
                        tb = th_t[iy + sy][ix];
                        pb = ph_t[iy + sy][ix];
                    end
                    if (present(ix + sx, iy + sy))
                    begin
                        td = th_t[iy + sy][ix + sx];
                        pd = ph_t[iy + sy][ix + sx];
                    end
                    d = (xa - xc) * (yb - yc);
                    if (d == 0)
                    begin
                        th = th_t[iy][ix];
                        ph = ph_t[iy][ix];
                    end
                    else
                    begin
                        th = mix(th_t[iy][ix], ta, tb, td, xc, xa, yc, yb, it.x, it.y, d);
                        ph = mix(ph_t[iy][ix], pa, pb, pd, xc, xa, yc, yb, it.x, it.y, d);
                    end
                    res.found = 1'b1;
                    res.id = id_t[iy][ix];
                    res.th = th[17:0];
                    res.ph = ph[17:0];
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(interp_result_t got);
            interp_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: found %0d id %0d th %0d ph %0d",
                             got.found, got.id, $signed(got.th), $signed(got.ph));
                return;
            end
            want = pending.pop_front();
            if (got != want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp found %0d id %0d th %0d ph %0d, got %0d %0d %0d %0d",
                             want.found, want.id, $signed(want.th), $signed(want.ph),
                             got.found, got.id, $signed(got.th), $signed(got.ph));
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                kind = 1'b0;
    logic [4:0]          grid_col = '0;
    logic [4:0]          grid_row = '0;
    logic [9:0]          tile_id = '0;
    logic signed [17:0]  pos_x = '0;
    logic signed [17:0]  pos_y = '0;
    logic signed [17:0]  load_theta = '0;
    logic signed [17:0]  load_phi = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                found;
    logic [9:0]          hit_tile_id;
    logic signed [17:0]  interp_theta;
    logic signed [17:0]  interp_phi;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = 1'b0;
    logic [13:0]         cfg_data = '0;

    interp_scoreboard    sb = new();
    int                  sent = 0;
    int                  send_idle_pct = 17;
    int                  recv_stall_pct = 81;

    pmt_grid_bilinear_interpolator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .grid_col(grid_col), .grid_row(grid_row), .tile_id(tile_id),
        .pos_x(pos_x), .pos_y(pos_y), .load_theta(load_theta), .load_phi(load_phi),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .hit_tile_id(hit_tile_id),
        .interp_theta(interp_theta), .interp_phi(interp_phi),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{found, hit_tile_id, interp_theta, interp_phi});
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic longint rnd(longint lo, longint hi);
        return lo + longint'($urandom_range(int'(hi - lo)));
    endfunction

    function automatic grid_item_t noise_item();
        grid_item_t it;
        it.kind = $urandom_range(1);
        it.col = $urandom_range(31);
        it.row = $urandom_range(31);
        it.id = $urandom_range(1023);
        it.x = rnd(-131072, 131071);
        it.y = rnd(-131072, 131071);
        it.th = rnd(-131072, 131071);
        it.ph = rnd(-131072, 131071);
        return it;
    endfunction

    task automatic send(grid_item_t it);
        if (sent < 650)
        begin
            send_idle_pct = 17;
            recv_stall_pct = 81;
        end
        else if (sent < 1300)
        begin
            send_idle_pct = 81;
            recv_stall_pct = 17;
        end
        else
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= it.kind;
        grid_col <= it.col;
        grid_row <= it.row;
        tile_id <= it.id;
        pos_x <= it.x[17:0];
        pos_y <= it.y[17:0];
        load_theta <= it.th[17:0];
        load_phi <= it.ph[17:0];
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[13:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic grid_phase(int unsigned size, int unsigned gap, int nq);
        grid_item_t it;
        longint p, span;
        int n;
        drain();
        write_reg(REG_TILE_SIZE, size);
        write_reg(REG_TILE_GAP, gap);
        p = size + gap;
        n = 1 + 262142 / p;
        if (n > 6)
            n = 6;
        span = n * p;
        if (span > 262000)
            span = 262000;
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                if ($urandom_range(9) < 8)
                begin
                    it = noise_item();
                    it.kind = 1'b0;
                    it.col = c;
                    it.row = r;
                    it.x = EDGE_POS - c * p - rnd(0, p / 8);
                    it.y = EDGE_POS - r * p - rnd(0, p / 8);
                    if ($urandom_range(7) != 0)
                    begin
                        it.th = rnd(-20000, 20000);
                        it.ph = rnd(-20000, 20000);
                    end
                    send(it);
                end
            end
        end
        for (int q = 0; q < nq; q++)
        begin
            it = noise_item();
            if ($urandom_range(9) != 0)
            begin
                it.kind = 1'b1;
                it.x = EDGE_POS - rnd(0, span);
                it.y = EDGE_POS - rnd(0, span);
            end
            send(it);
        end
    endtask

    initial
    begin
        grid_item_t it;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed: empty table, out-of-grid loads, field extremes
        it = '{1'b1, 5'd0, 5'd0, 10'd0, 0, 0, 0, 0};
        send(it);
        it = '{1'b0, 5'd24, 5'd3, 10'd1023, 131071, 131071, 131071, 131071};
        send(it);
        it = '{1'b0, 5'd2, 5'd31, 10'd5, 100, 100, 5, 5};
        send(it);
        it = '{1'b1, 5'd0, 5'd0, 10'd0, 131071, -131072, 0, 0};
        send(it);
        it = '{1'b0, 5'd0, 5'd0, 10'd1023, 131071, 131071, 131071, -131072};
        send(it);
        it = '{1'b0, 5'd23, 5'd23, 10'd0, -131072, -131072, -131072, 131071};
        send(it);
        it = '{1'b0, 5'd1, 5'd0, 10'd7, 131071 - 3392, 131071, -131072, 131071};
        send(it);
        it = '{1'b0, 5'd0, 5'd1, 10'd8, 131071, 131071 - 3392, 131071, -131072};
        send(it);
        it = '{1'b0, 5'd1, 5'd1, 10'd9, 131071 - 3392, 131071 - 3392, 131071, 131071};
        send(it);
        it = '{1'b1, 5'd31, 5'd31, 10'd1023, 131071, 131071, 0, 0};
        send(it);
        it = '{1'b1, 5'd0, 5'd0, 10'd0, 131071 - 1696, 131071 - 1696, 0, 0};
        send(it);
        it = '{1'b1, 5'd0, 5'd0, 10'd0, -131072, -131072, 0, 0};
        send(it);
        it = '{1'b1, 5'd0, 5'd0, 10'd0, 131071 - 5000, 131071 - 6000, 0, 0};
        send(it);
        it = '{1'b1, 5'd0, 5'd0, 10'd0, 0, 131071, 0, 0};
        send(it);
        grid_phase(SIZE_RESET, GAP_RESET, 220);
        grid_phase(1, 0, 220);
        grid_phase(16383, 16383, 220);
        grid_phase(1, 16383, 220);
        grid_phase(16383, 0, 220);
        grid_phase($urandom_range(16383, 1), $urandom_range(16383), 220);
        grid_phase($urandom_range(4000, 1), $urandom_range(300), 220);
        grid_phase($urandom_range(4000, 1), $urandom_range(300), 220);
        drain();
        if (sb.errors == 0)
            $display("[pmt_grid_bilinear_interpolator] OK");
        else
            $display("[pmt_grid_bilinear_interpolator] ERROR");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("[pmt_grid_bilinear_interpolator] ERROR");
        $finish;
    end

endmodule
